// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL file nfc_frame_receive_checker.sv.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/nfcrc_pkg.sv =====
// Package for the frame receive checker: widths, register map, phase and status codes.
// No dependencies.
`timescale 1ns / 1ps

package nfcrc_pkg;

    localparam int DATA_W     = 8;
    localparam int LEN_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [DATA_W-1:0] BYTE_ZERO     = 8'h00;
    localparam logic [DATA_W-1:0] BYTE_ALL_ONES = 8'hFF;

    localparam logic [DATA_W-1:0] RST_START_FIRST  = 8'h00;
    localparam logic [DATA_W-1:0] RST_START_SECOND = 8'hFF;
    localparam logic [DATA_W-1:0] RST_HOST_ADDR    = 8'hD5;
    localparam logic [DATA_W-1:0] RST_ERROR_ADDR   = 8'h7F;

    typedef enum logic [1:0] {
        REG_START_FIRST  = 2'd0,
        REG_START_SECOND = 2'd1,
        REG_HOST_ADDR    = 2'd2,
        REG_ERROR_ADDR   = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START1 = 4'd1,
        PH_START2 = 4'd2,
        PH_PAIRA  = 4'd3,
        PH_PAIRB  = 4'd4,
        PH_EXTHI  = 4'd5,
        PH_EXTLO  = 4'd6,
        PH_EXTLCS = 4'd7,
        PH_IDENT  = 4'd8,
        PH_BODY   = 4'd9
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD      = 3'd0,
        ST_ACK       = 3'd1,
        ST_NACK      = 3'd2,
        ST_DEV_ERR   = 3'd3,
        ST_BAD_START = 3'd4,
        ST_BAD_ADDR  = 3'd5,
        ST_BAD_LCS   = 3'd6,
        ST_BAD_DCS   = 3'd7
    } status_t;

endpackage

// ===== sv/nfc_frame_receive_checker.sv =====
// Frame receive checker top level: byte parser, checksum checks, APB register file.
// Depends on nfcrc_pkg and assert_macros.svh.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | in_valid / in_ready        | rx_byte, frame_start
//  output   | out_valid / out_ready      | payload_valid, payload_byte, frame_done,
//           |                            | status, extended_frame, frame_length
//  config   | psel penable pwrite pready | paddr, pwdata, prdata
//
// One byte per cycle while the output is not stalled; each transfer is parsed
// combinationally and its result is written to the output register at the accepting edge.
// in_ready is high whenever the output register is empty or being drained.
// rst_n clears parser state, the output valid and restores register defaults.
// A stall on the output holds the result and blocks further input transfers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nfc_frame_receive_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nfcrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nfcrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nfcrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [nfcrc_pkg::DATA_W-1:0]     rx_byte,
    input  logic                             frame_start,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             payload_valid,
    output logic [nfcrc_pkg::DATA_W-1:0]     payload_byte,
    output logic                             frame_done,
    output logic [nfcrc_pkg::STATUS_W-1:0]   status,
    output logic                             extended_frame,
    output logic [nfcrc_pkg::LEN_W-1:0]      frame_length
);
    import nfcrc_pkg::*;

    logic [DATA_W-1:0]   start_first_reg;
    logic [DATA_W-1:0]   start_second_reg;
    logic [DATA_W-1:0]   host_addr_reg;
    logic [DATA_W-1:0]   error_addr_reg;

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    length_reg, length_next;
    logic                lsum_ok_reg, lsum_ok_next;
    logic [LEN_W-1:0]    remaining_reg, remaining_next;
    logic [DATA_W-1:0]   sum_reg, sum_next;
    logic                ext_reg, ext_next;

    logic                out_valid_reg;
    logic                payload_valid_reg;
    logic [DATA_W-1:0]   payload_byte_reg;
    logic                frame_done_reg;
    status_t             status_reg;
    logic                ext_out_reg;
    logic [LEN_W-1:0]    length_out_reg;

    logic                pvalid_c;
    logic [DATA_W-1:0]   pbyte_c;
    logic                done_c;
    status_t             status_c;

    logic                in_fire;
    logic                cfg_write;
    reg_idx_t            cfg_idx;
    logic [DATA_W-1:0]   first_byte;
    logic [DATA_W-1:0]   pair_sum;
    logic [DATA_W-1:0]   ext_sum;
    logic [DATA_W-1:0]   data_sum;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    assign first_byte = length_reg[DATA_W-1:0];
    assign pair_sum   = first_byte + rx_byte;
    assign ext_sum    = length_reg[LEN_W-1:DATA_W] + length_reg[DATA_W-1:0] + rx_byte;
    assign data_sum   = sum_reg + rx_byte;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= RST_START_FIRST;
            start_second_reg <= RST_START_SECOND;
            host_addr_reg    <= RST_HOST_ADDR;
            error_addr_reg   <= RST_ERROR_ADDR;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_START_FIRST:  start_first_reg  <= pwdata[DATA_W-1:0];
                REG_START_SECOND: start_second_reg <= pwdata[DATA_W-1:0];
                REG_HOST_ADDR:    host_addr_reg    <= pwdata[DATA_W-1:0];
                REG_ERROR_ADDR:   error_addr_reg   <= pwdata[DATA_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_START_FIRST:  prdata = {{(APB_DATA_W-DATA_W){1'b0}}, start_first_reg};
            REG_START_SECOND: prdata = {{(APB_DATA_W-DATA_W){1'b0}}, start_second_reg};
            REG_HOST_ADDR:    prdata = {{(APB_DATA_W-DATA_W){1'b0}}, host_addr_reg};
            REG_ERROR_ADDR:   prdata = {{(APB_DATA_W-DATA_W){1'b0}}, error_addr_reg};
            default:          prdata = '0;
        endcase
    end

    // result of the byte in flight
    always_comb
    begin
        pvalid_c = 1'b0;
        pbyte_c  = BYTE_ZERO;
        done_c   = 1'b0;
        status_c = ST_GOOD;
        if (!frame_start)
        begin
            unique case (phase_reg)
                PH_START1:
                begin
                    if (rx_byte != start_first_reg)
                    begin
                        done_c   = 1'b1;
                        status_c = ST_BAD_START;
                    end
                end
                PH_START2:
                begin
                    if (rx_byte != start_second_reg)
                    begin
                        done_c   = 1'b1;
                        status_c = ST_BAD_START;
                    end
                end
                PH_PAIRB:
                begin
                    if (first_byte == BYTE_ZERO && rx_byte == BYTE_ALL_ONES)
                    begin
                        done_c   = 1'b1;
                        status_c = ST_ACK;
                    end
                    else if (first_byte == BYTE_ALL_ONES && rx_byte == BYTE_ZERO)
                    begin
                        done_c   = 1'b1;
                        status_c = ST_NACK;
                    end
                end
                PH_IDENT:
                begin
                    if (rx_byte == host_addr_reg)
                    begin
                        if (!lsum_ok_reg)
                        begin
                            done_c   = 1'b1;
                            status_c = ST_BAD_LCS;
                        end
                        else if (length_reg == '0)
                        begin
                            // identifier doubles as data checksum
                            done_c   = 1'b1;
                            status_c = (rx_byte == BYTE_ZERO) ? ST_GOOD : ST_BAD_DCS;
                        end
                    end
                    else if (!ext_reg && length_reg == LEN_W'(1) && lsum_ok_reg
                             && rx_byte == error_addr_reg)
                    begin
                        done_c   = 1'b1;
                        status_c = ST_DEV_ERR;
                    end
                    else
                    begin
                        done_c   = 1'b1;
                        status_c = ST_BAD_ADDR;
                    end
                end
                PH_BODY:
                begin
                    if (remaining_reg != '0)
                    begin
                        pvalid_c = 1'b1;
                        pbyte_c  = rx_byte;
                    end
                    else
                    begin
                        done_c = 1'b1;
                        if (data_sum == BYTE_ZERO)
                            status_c = ST_GOOD;
                        else if (!ext_reg && length_reg == LEN_W'(1)
                                 && sum_reg == error_addr_reg)
                            status_c = ST_DEV_ERR;
                        else
                            status_c = ST_BAD_DCS;
                    end
                end
                default: ;
            endcase
        end
    end

    // parser next state
    always_comb
    begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        lsum_ok_next   = lsum_ok_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        ext_next       = ext_reg;
        if (frame_start)
        begin
            phase_next     = PH_START1;
            length_next    = '0;
            lsum_ok_next   = 1'b0;
            remaining_next = '0;
            sum_next       = '0;
            ext_next       = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_START1: phase_next = PH_START2;
                PH_START2: phase_next = PH_PAIRA;
                PH_PAIRA:
                begin
                    length_next = {{(LEN_W-DATA_W){1'b0}}, rx_byte};
                    phase_next  = PH_PAIRB;
                end
                PH_PAIRB:
                begin
                    if ((first_byte == BYTE_ZERO && rx_byte == BYTE_ALL_ONES) ||
                        (first_byte == BYTE_ALL_ONES && rx_byte == BYTE_ZERO))
                    begin
                        length_next = '0;
                    end
                    else if (first_byte == BYTE_ALL_ONES && rx_byte == BYTE_ALL_ONES)
                    begin
                        length_next = '0;
                        ext_next    = 1'b1;
                        phase_next  = PH_EXTHI;
                    end
                    else
                    begin
                        lsum_ok_next = (pair_sum == BYTE_ZERO);
                        phase_next   = PH_IDENT;
                    end
                end
                PH_EXTHI:
                begin
                    length_next = {rx_byte, BYTE_ZERO};
                    phase_next  = PH_EXTLO;
                end
                PH_EXTLO:
                begin
                    length_next = {length_reg[LEN_W-1:DATA_W], rx_byte};
                    phase_next  = PH_EXTLCS;
                end
                PH_EXTLCS:
                begin
                    lsum_ok_next = (ext_sum == BYTE_ZERO);
                    phase_next   = PH_IDENT;
                end
                PH_IDENT:
                begin
                    if (rx_byte == host_addr_reg && lsum_ok_reg && length_reg != '0)
                    begin
                        sum_next       = rx_byte;
                        remaining_next = length_reg - LEN_W'(1);
                        phase_next     = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (remaining_reg != '0)
                    begin
                        sum_next       = data_sum;
                        remaining_next = remaining_reg - LEN_W'(1);
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
            if (done_c)
                phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            length_reg    <= '0;
            lsum_ok_reg   <= 1'b0;
            remaining_reg <= '0;
            sum_reg       <= '0;
            ext_reg       <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            lsum_ok_reg   <= lsum_ok_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            ext_reg       <= ext_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            payload_valid_reg <= pvalid_c;
            payload_byte_reg  <= pbyte_c;
            frame_done_reg    <= done_c;
            status_reg        <= status_c;
            ext_out_reg       <= ext_next;
            length_out_reg    <= length_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_valid  = payload_valid_reg;
    assign payload_byte   = payload_byte_reg;
    assign frame_done     = frame_done_reg;
    assign status         = status_reg;
    assign extended_frame = ext_out_reg;
    assign frame_length   = length_out_reg;

    `CHK_IMPL(a_payload_xor_done, out_valid_reg, !(payload_valid_reg && frame_done_reg))
    `CHK_IMPL(a_status_only_on_done, out_valid_reg && !frame_done_reg, status_reg == ST_GOOD)
    `CHK_NEXT(a_verdict_idles, in_fire && !frame_start && done_c, phase_reg == PH_IDLE)
    `CHK_NEXT(a_start_restarts, in_fire && frame_start,
              phase_reg == PH_START1 && length_reg == '0 && !ext_reg)
    `CHK_IMPL(a_remaining_in_body, phase_reg != PH_BODY, remaining_reg == '0)

endmodule

// ===== sim/testbench.sv =====
// Testbench for nfc_frame_receive_checker: drives reader frames byte by byte and
// checks every result against a built-in frame parser with its own register copy.
// Depends on nfcrc_pkg and the nfc_frame_receive_checker RTL.
`timescale 1ns / 1ps

module testbench;
    import nfcrc_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 780;
    localparam int LONG_HOLD    = 150;

    typedef struct packed {
        logic              pvalid;
        logic [DATA_W-1:0] pbyte;
        logic              done;
        status_t           st;
        logic              ext;
        logic [LEN_W-1:0]  len;
    } frame_result_t;

    typedef enum int {
        FL_NONE,
        FL_START_FIRST,
        FL_START_SECOND,
        FL_LEN_SUM,
        FL_ADDR,
        FL_DATA_SUM,
        FL_CUT
    } frame_flaw_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [DATA_W-1:0]     rx_byte = '0;
    logic                  frame_start = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  payload_valid;
    logic [DATA_W-1:0]     payload_byte;
    logic                  frame_done;
    logic [STATUS_W-1:0]   status;
    logic                  extended_frame;
    logic [LEN_W-1:0]      frame_length;

    // parser copy
    phase_t            p_phase  = PH_IDLE;
    logic [LEN_W-1:0]  p_len    = '0;
    logic              p_lcs_ok = 1'b0;
    logic [LEN_W-1:0]  p_left   = '0;
    logic [DATA_W-1:0] p_sum    = '0;
    logic              p_ext    = 1'b0;

    logic [DATA_W-1:0] cfg_start1 = RST_START_FIRST;
    logic [DATA_W-1:0] cfg_start2 = RST_START_SECOND;
    logic [DATA_W-1:0] cfg_host   = RST_HOST_ADDR;
    logic [DATA_W-1:0] cfg_err    = RST_ERROR_ADDR;

    frame_result_t     expected_q[$];
    logic [DATA_W-1:0] frame_buf[$];

    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold = 0;
    int rx_stall = 0;
    int idle_cycles = 0;
    int mismatch_count = 0;
    int result_count = 0;
    int transfers_in = 0;
    int payload_count = 0;
    int items_sent = 0;
    int config_writes = 0;
    int verdict_count[8];

    nfc_frame_receive_checker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .frame_done     (frame_done),
        .status         (status),
        .extended_frame (extended_frame),
        .frame_length   (frame_length)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic parse_byte(input logic [DATA_W-1:0] b, input logic fs);
        frame_result_t     r;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] sum8;
        r = '0;
        if (fs) begin
            p_len    = '0;
            p_lcs_ok = 1'b0;
            p_left   = '0;
            p_sum    = '0;
            p_ext    = 1'b0;
            p_phase  = PH_START1;
        end
        else begin
            case (p_phase)
                PH_START1:
                    if (b == cfg_start1)
                        p_phase = PH_START2;
                    else
                    begin
                        r.done = 1'b1;
                        r.st   = ST_BAD_START;
                    end
                PH_START2:
                    if (b == cfg_start2)
                        p_phase = PH_PAIRA;
                    else
                    begin
                        r.done = 1'b1;
                        r.st   = ST_BAD_START;
                    end
                PH_PAIRA:
                begin
                    p_len   = {8'h00, b};
                    p_phase = PH_PAIRB;
                end
                PH_PAIRB:
                begin
                    first = p_len[7:0];
                    if (first == BYTE_ZERO && b == BYTE_ALL_ONES) begin
                        p_len  = '0;
                        r.done = 1'b1;
                        r.st   = ST_ACK;
                    end
                    else if (first == BYTE_ALL_ONES && b == BYTE_ZERO) begin
                        p_len  = '0;
                        r.done = 1'b1;
                        r.st   = ST_NACK;
                    end
                    else if (first == BYTE_ALL_ONES && b == BYTE_ALL_ONES) begin
                        p_len   = '0;
                        p_ext   = 1'b1;
                        p_phase = PH_EXTHI;
                    end
                    else begin
                        sum8     = first + b;
                        p_lcs_ok = (sum8 == BYTE_ZERO);
                        p_phase  = PH_IDENT;
                    end
                end
                PH_EXTHI:
                begin
                    p_len   = {b, 8'h00};
                    p_phase = PH_EXTLO;
                end
                PH_EXTLO:
                begin
                    p_len[7:0] = b;
                    p_phase    = PH_EXTLCS;
                end
                PH_EXTLCS:
                begin
                    sum8     = p_len[15:8] + p_len[7:0] + b;
                    p_lcs_ok = (sum8 == BYTE_ZERO);
                    p_phase  = PH_IDENT;
                end
                PH_IDENT:
                    if (b == cfg_host) begin
                        if (!p_lcs_ok) begin
                            r.done = 1'b1;
                            r.st   = ST_BAD_LCS;
                        end
                        else if (p_len == 0) begin
                            r.done = 1'b1;
                            r.st   = (b == BYTE_ZERO) ? ST_GOOD : ST_BAD_DCS;
                        end
                        else begin
                            p_sum   = b;
                            p_left  = p_len - 1'b1;
                            p_phase = PH_BODY;
                        end
                    end
                    else if (!p_ext && p_len == 1 && p_lcs_ok && b == cfg_err) begin
                        r.done = 1'b1;
                        r.st   = ST_DEV_ERR;
                    end
                    else begin
                        r.done = 1'b1;
                        r.st   = ST_BAD_ADDR;
                    end
                PH_BODY:
                    if (p_left != 0) begin
                        r.pvalid = 1'b1;
                        r.pbyte  = b;
                        p_sum    = p_sum + b;
                        p_left   = p_left - 1'b1;
                    end
                    else begin
                        r.done = 1'b1;
                        sum8   = p_sum + b;
                        if (sum8 == BYTE_ZERO)
                            r.st = ST_GOOD;
                        else if (!p_ext && p_len == 1 && p_sum == cfg_err)
                            r.st = ST_DEV_ERR;
                        else
                            r.st = ST_BAD_DCS;
                    end
                default:
                    p_phase = PH_IDLE;
            endcase
            if (r.done)
                p_phase = PH_IDLE;
        end
        r.ext = p_ext;
        r.len = p_len;
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at result %0d: %s", result_count, what);
    endtask

    task automatic check_result();
        frame_result_t want;
        if (expected_q.size() == 0) begin
            report_mismatch("result with no transfer pending");
        end
        else begin
            want = expected_q.pop_front();
            if (payload_valid !== want.pvalid)
                report_mismatch($sformatf("payload_valid %b, want %b",
                                          payload_valid, want.pvalid));
            if (payload_byte !== want.pbyte)
                report_mismatch($sformatf("payload_byte %h, want %h",
                                          payload_byte, want.pbyte));
            if (frame_done !== want.done)
                report_mismatch($sformatf("frame_done %b, want %b", frame_done, want.done));
            if (status !== want.st)
                report_mismatch($sformatf("status %0d, want %0d", status, want.st));
            if (extended_frame !== want.ext)
                report_mismatch($sformatf("extended_frame %b, want %b",
                                          extended_frame, want.ext));
            if (frame_length !== want.len)
                report_mismatch($sformatf("frame_length %h, want %h",
                                          frame_length, want.len));
            if (want.done)
                verdict_count[want.st]++;
            if (want.pvalid)
                payload_count++;
        end
        result_count++;
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready) begin
                parse_byte(rx_byte, frame_start);
                transfers_in++;
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (rx_hold > 0) begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else if (rx_stall > 0) begin
                out_ready <= 1'b0;
                rx_stall--;
            end
            else begin
                n = pick_gap(rx_stall_pct);
                if (n > 0) begin
                    out_ready <= 1'b0;
                    rx_stall = n - 1;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_item(input logic [DATA_W-1:0] b, input logic fs);
        int gap;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_frame_buf();
        for (int i = 0; i < frame_buf.size(); i++)
            send_item(frame_buf[i], i == 0);
        items_sent += frame_buf.size();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_START_FIRST:  cfg_start1 = v;
            REG_START_SECOND: cfg_start2 = v;
            REG_HOST_ADDR:    cfg_host   = v;
            REG_ERROR_ADDR:   cfg_err    = v;
            default: ;
        endcase
        config_writes++;
    endtask

    task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] host, input logic [7:0] err);
        apb_write(REG_START_FIRST, s1);
        apb_write(REG_START_SECOND, s2);
        apb_write(REG_HOST_ADDR, host);
        apb_write(REG_ERROR_ADDR, err);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (prdata !== {{(APB_DATA_W-DATA_W){1'b0}}, err})
            report_mismatch($sformatf("prdata %h, want %h", prdata, err));
    endtask

    task automatic build_ack(input bit nack);
        frame_buf.delete();
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(cfg_start1);
        frame_buf.push_back(cfg_start2);
        frame_buf.push_back(nack ? BYTE_ALL_ONES : BYTE_ZERO);
        frame_buf.push_back(nack ? BYTE_ZERO : BYTE_ALL_ONES);
        repeat ($urandom_range(0, 2)) frame_buf.push_back(8'($urandom));
    endtask

    // flen counts the identifier plus payload bytes
    task automatic build_frame(input bit ext, input int flen, input logic [7:0] ident,
                               input frame_flaw_t flaw);
        logic [LEN_W-1:0]  l16;
        logic [DATA_W-1:0] lcs;
        logic [DATA_W-1:0] sum;
        logic [DATA_W-1:0] b;
        int                lcs_pos;
        int                ident_pos;
        int                hi;
        l16 = flen[LEN_W-1:0];
        frame_buf.delete();
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(cfg_start1);
        frame_buf.push_back(cfg_start2);
        if (ext) begin
            frame_buf.push_back(BYTE_ALL_ONES);
            frame_buf.push_back(BYTE_ALL_ONES);
            frame_buf.push_back(l16[15:8]);
            frame_buf.push_back(l16[7:0]);
            lcs = BYTE_ZERO - l16[15:8] - l16[7:0];
        end
        else begin
            frame_buf.push_back(l16[7:0]);
            lcs = BYTE_ZERO - l16[7:0];
        end
        lcs_pos = frame_buf.size();
        frame_buf.push_back(lcs);
        ident_pos = frame_buf.size();
        frame_buf.push_back(ident);
        sum = ident;
        if (flen > 0) begin
            for (int i = 0; i < flen - 1; i++) begin
                b = 8'($urandom);
                frame_buf.push_back(b);
                sum = sum + b;
            end
            frame_buf.push_back(BYTE_ZERO - sum);
        end
        case (flaw)
            FL_START_FIRST:  frame_buf[1] ^= 8'($urandom_range(1, 255));
            FL_START_SECOND: frame_buf[2] ^= 8'($urandom_range(1, 255));
            FL_LEN_SUM:      frame_buf[lcs_pos] ^= 8'($urandom_range(1, 255));
            FL_ADDR:         frame_buf[ident_pos] ^= 8'($urandom_range(1, 255));
            FL_DATA_SUM:
                if (flen > 0)
                    frame_buf[frame_buf.size()-1] ^= 8'($urandom_range(1, 255));
            FL_CUT:
            begin
                hi = frame_buf.size() - 1;
                if (ident_pos + 6 < hi)
                    hi = ident_pos + 6;
                hi = $urandom_range(2, hi);
                while (frame_buf.size() > hi) void'(frame_buf.pop_back());
            end
            default: ;
        endcase
    endtask

    task automatic send_frame(input bit ext, input int flen, input logic [7:0] ident,
                              input frame_flaw_t flaw);
        build_frame(ext, flen, ident, flaw);
        send_frame_buf();
    endtask

    task automatic random_frame();
        int          pick;
        int          flen;
        bit          ext;
        logic [7:0]  ident;
        frame_flaw_t flaw;
        pick = $urandom_range(99);
        if (pick < 6) begin
            build_ack(pick[0]);
            send_frame_buf();
        end
        else if (pick < 10) begin
            repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
        end
        else begin
            ext  = ($urandom_range(3) == 0);
            pick = $urandom_range(99);
            if (pick < 70)
                flen = $urandom_range(0, 6);
            else if (pick < 95)
                flen = $urandom_range(7, 40);
            else
                flen = ext ? $urandom_range(256, 65535) : $urandom_range(200, 255);
            flaw = ($urandom_range(99) < 65) ? FL_NONE : frame_flaw_t'($urandom_range(1, 6));
            if (flen > 40 && (ext || $urandom_range(3) != 0))
                flaw = FL_CUT;
            pick = $urandom_range(99);
            if (pick < 85)
                ident = cfg_host;
            else if (pick < 93) begin
                ident = cfg_err;
                ext   = 1'b0;
                flen  = 1;
            end
            else
                ident = 8'($urandom);
            send_frame(ext, flen, ident, flaw);
        end
    endtask

    task automatic test_ignored_bytes();
        send_item(BYTE_ZERO, 1'b0);
        send_item(BYTE_ALL_ONES, 1'b0);
        drain();
    endtask

    task automatic test_ack_nack();
        build_ack(1'b0);
        send_frame_buf();
        build_ack(1'b1);
        send_frame_buf();
        drain();
    endtask

    task automatic test_good_frames();
        send_frame(1'b0, 1, cfg_host, FL_NONE);
        send_frame(1'b0, 3, cfg_host, FL_NONE);
        send_frame(1'b1, 2, cfg_host, FL_NONE);
        drain();
    endtask

    task automatic test_bad_frames();
        send_frame(1'b0, 2, cfg_host, FL_START_FIRST);
        send_frame(1'b0, 2, cfg_host, FL_START_SECOND);
        send_frame(1'b0, 2, cfg_host, FL_LEN_SUM);
        send_frame(1'b1, 2, cfg_host, FL_LEN_SUM);
        send_frame(1'b0, 2, cfg_host, FL_ADDR);
        send_frame(1'b0, 2, cfg_host, FL_DATA_SUM);
        send_frame(1'b0, 1, cfg_err, FL_NONE);
        // longest extended length, abandoned by the next frame start
        send_frame(1'b1, 65535, cfg_host, FL_CUT);
        send_frame(1'b0, 255, cfg_host, FL_CUT);
        drain();
    endtask

    task automatic test_shared_address();
        set_config(RST_START_FIRST, RST_START_SECOND, 8'h42, 8'h42);
        send_frame(1'b0, 1, cfg_host, FL_DATA_SUM);
        send_frame(1'b0, 0, cfg_host, FL_NONE);
        drain();
        set_config(RST_START_FIRST, RST_START_SECOND, BYTE_ZERO, RST_ERROR_ADDR);
        send_frame(1'b0, 0, cfg_host, FL_NONE);
        drain();
    endtask

    task automatic test_backpressure();
        tx_gap_pct = 0;
        rx_hold    = LONG_HOLD;
        send_frame(1'b0, 6, cfg_host, FL_NONE);
        send_frame(1'b1, 4, cfg_host, FL_NONE);
        drain();
    endtask

    task automatic test_random_settings();
        logic [7:0] setting[6][4];
        int         tx_pct[6];
        int         rx_pct[6];
        int         target;
        setting = '{'{8'h00, 8'hFF, 8'hD5, 8'h7F}, '{8'h00, 8'h00, 8'h00, 8'h00},
                    '{8'hFF, 8'hFF, 8'hFF, 8'hFF}, '{8'hA5, 8'h5A, 8'h42, 8'h42},
                    '{8'hFF, 8'h00, 8'h01, 8'hFE}, '{8'h12, 8'h34, 8'hD5, 8'hD4}};
        tx_pct  = '{30, 0, 60, 10, 40, 20};
        rx_pct  = '{30, 0, 10, 60, 40, 20};
        for (int s = 0; s < 6; s++) begin
            set_config(setting[s][0], setting[s][1], setting[s][2], setting[s][3]);
            tx_gap_pct   = tx_pct[s];
            rx_stall_pct = rx_pct[s];
            target = items_sent + RANDOM_ITEMS / 6;
            while (items_sent < target) random_frame();
            drain();
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        test_ignored_bytes();
        test_ack_nack();
        test_good_frames();
        test_bad_frames();
        test_shared_address();
        test_backpressure();
        test_random_settings();
        repeat (10) @(posedge clk);
        $display("covered %0d byte transfers, %0d payload bytes, %0d register writes",
                 transfers_in, payload_count, config_writes);
        $display("verdicts good/ack/nack/deverr/start/addr/lensum/datasum: %0d/%0d/%0d/%0d/%s",
                 verdict_count[0], verdict_count[1], verdict_count[2], verdict_count[3],
                 $sformatf("%0d/%0d/%0d/%0d", verdict_count[4], verdict_count[5],
                           verdict_count[6], verdict_count[7]));
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== nfc_frame_receive_checker.f =====
+incdir+sv
sv/nfcrc_pkg.sv
sv/nfc_frame_receive_checker.sv
sim/testbench.sv
